FILE: hdl/assert_macros.svh
// assertion helpers used by the queue unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tbeq_pkg.sv
`default_nettype none

package tbeq_pkg;

    // fixed field widths
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned HANDLE_W = 32;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned ACT_W    = 2;
    localparam int unsigned STAT_W   = 3;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ENQ   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_ENQUEUED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DELIVERED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_ANTI      = 3'd4;
    localparam logic [STAT_W-1:0] STAT_CLEARED   = 3'd5;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ENQ,
        S_DEQ,
        S_CLR
    } t_state;

    // per-cycle operation of the cell row
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_POP
    } t_cell_op;

    // one held event
    typedef struct packed {
        logic [TIME_W-1:0]   time_val;
        logic [HANDLE_W-1:0] handle;
        logic                anti;
    } t_entry;

    // control broadcast to every cell
    typedef struct packed {
        t_cell_op         op;
        logic [CNT_W-1:0] count;
        t_entry           entry;
    } t_row_ctl;

endpackage

`default_nettype wire

FILE: hdl/timestamp_bucketed_event_queue_unit.sv
`default_nettype none
`include "assert_macros.svh"

// Event queue sorted by receive time, held in a row of EVENT_DEPTH cells that
// shift one position on each insert or pop; equal times keep arrival order.
// One transaction is taken at a time (o_s_tready is high only when the
// sequencer is idle). An enqueue inserts the event in parallel, cells from the
// insertion point on shifting right, and loads its result; a full row loads
// STAT_FULL without inserting. A clear empties the queue and loads its result.
// Dequeue emits the head cell and the row shifts left once per result. Any
// cycle in which the single output register is still held by the sink stalls
// the sequencer. Action code 3 is dropped without a result.

module timestamp_bucketed_event_queue_unit #(
    parameter int unsigned EVENT_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // event_handle[31:0], event_time[63:32]
    input  wire logic [2:0]  i_s_tuser,   // action[1:0], event_is_anti[2]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,   // out_handle[31:0], out_time[63:32],
                                          // queue_count[70:64], zero[71]
    output logic             o_m_tlast,   // is_last
    output logic [2:0]       o_m_tuser    // status[2:0]
);

    localparam int unsigned CNT_W = tbeq_pkg::CNT_W;

    tbeq_pkg::t_state   r_state;
    tbeq_pkg::t_state   n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    tbeq_pkg::t_entry   r_in;
    tbeq_pkg::t_row_ctl row_ctl;
    tbeq_pkg::t_entry   head;
    tbeq_pkg::t_entry   second;
    logic               in_accept;
    logic               out_free;

    // result being produced this cycle
    logic                        emit;
    logic [tbeq_pkg::HANDLE_W-1:0] res_handle;
    logic [tbeq_pkg::TIME_W-1:0]   res_time;
    logic                        res_last;
    logic [tbeq_pkg::STAT_W-1:0] res_status;

    // output register
    logic                        r_m_valid;
    logic [tbeq_pkg::HANDLE_W-1:0] r_m_handle;
    logic [tbeq_pkg::TIME_W-1:0]   r_m_time;
    logic [CNT_W-1:0]            r_m_count;
    logic                        r_m_last;
    logic [tbeq_pkg::STAT_W-1:0] r_m_status;

    assign o_s_tready = (r_state == tbeq_pkg::S_IDLE);
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;

    // sorted cell row
    tbeq_row #(
        .DEPTH(EVENT_DEPTH)
    ) u_row (
        .i_clk   (i_clk),
        .i_ctl   (row_ctl),
        .o_head  (head),
        .o_second(second)
    );

    // sequencer: next state, row operation and result
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        row_ctl.op    = tbeq_pkg::CELL_HOLD;
        row_ctl.count = r_count;
        row_ctl.entry = r_in;
        emit          = 1'b0;
        res_handle    = '0;
        res_time      = '0;
        res_last      = 1'b1;
        res_status    = tbeq_pkg::STAT_ENQUEUED;
        case (r_state)
            tbeq_pkg::S_IDLE: begin
                if (in_accept) begin
                    case (i_s_tuser[1:0])
                        tbeq_pkg::ACT_ENQ:   n_state = tbeq_pkg::S_ENQ;
                        tbeq_pkg::ACT_DEQ:   n_state = tbeq_pkg::S_DEQ;
                        tbeq_pkg::ACT_CLEAR: n_state = tbeq_pkg::S_CLR;
                        default:             n_state = tbeq_pkg::S_IDLE;
                    endcase
                end
            end
            tbeq_pkg::S_ENQ: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = tbeq_pkg::S_IDLE;
                    if (r_count >= CNT_W'(EVENT_DEPTH)) begin
                        res_status = tbeq_pkg::STAT_FULL;
                        res_time   = head.time_val;
                    end else begin
                        row_ctl.op = tbeq_pkg::CELL_INS;
                        n_count    = r_count + 1'b1;
                        // new event becomes head when it sorts before cell 0
                        if (r_count == '0 || head.time_val > r_in.time_val) begin
                            res_time = r_in.time_val;
                        end else begin
                            res_time = head.time_val;
                        end
                    end
                end
            end
            tbeq_pkg::S_DEQ: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_count == '0) begin
                        res_status = tbeq_pkg::STAT_EMPTY;
                        n_state    = tbeq_pkg::S_IDLE;
                    end else begin
                        // hand out the head, row shifts left
                        row_ctl.op = tbeq_pkg::CELL_POP;
                        n_count    = r_count - 1'b1;
                        res_handle = head.handle;
                        res_time   = head.time_val;
                        res_status = head.anti ? tbeq_pkg::STAT_ANTI
                                               : tbeq_pkg::STAT_DELIVERED;
                        res_last   = head.anti || (r_count == CNT_W'(1)) ||
                                     (second.time_val != head.time_val);
                        if (res_last) begin
                            n_state = tbeq_pkg::S_IDLE;
                        end
                    end
                end
            end
            tbeq_pkg::S_CLR: begin
                if (out_free) begin
                    emit       = 1'b1;
                    n_count    = '0;
                    res_status = tbeq_pkg::STAT_CLEARED;
                    n_state    = tbeq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tbeq_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tbeq_pkg::S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // input capture and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.handle   <= i_s_tdata[31:0];
            r_in.time_val <= i_s_tdata[63:32];
            r_in.anti     <= i_s_tuser[2];
        end
        if (emit) begin
            r_m_handle <= res_handle;
            r_m_time   <= res_time;
            r_m_count  <= n_count;
            r_m_last   <= res_last;
            r_m_status <= res_status;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_count, r_m_time, r_m_handle};
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_status;

    // checks
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(EVENT_DEPTH),
        "held count beyond depth")
    `ASSERT_IMPLY(a_row_sorted, i_clk, i_rst_n, r_count >= CNT_W'(2),
        head.time_val <= second.time_val, "cell row out of time order")
    `ASSERT_IMPLY(a_count_step, i_clk, i_rst_n, $past(r_state) != tbeq_pkg::S_CLR,
        (r_count == $past(r_count)) || (r_count == $past(r_count) + 7'd1) ||
        (r_count + 7'd1 == $past(r_count)), "held count jumped")

endmodule

`default_nettype wire

FILE: hdl/tbeq_cell.sv
`default_nettype none

module tbeq_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire logic              i_clk,
    input  wire tbeq_pkg::t_row_ctl i_ctl,
    input  wire tbeq_pkg::t_entry   i_left,
    input  wire logic              i_left_flag,
    input  wire tbeq_pkg::t_entry   i_right,
    output tbeq_pkg::t_entry        o_entry,
    output logic                    o_flag
);

    tbeq_pkg::t_entry r_entry;
    tbeq_pkg::t_entry n_entry;
    logic             occupied;

    // flag marks a free cell or one whose time lies beyond the new event
    assign occupied = tbeq_pkg::CNT_W'(IDX) < i_ctl.count;
    assign o_flag   = !occupied || (r_entry.time_val > i_ctl.entry.time_val);
    assign o_entry  = r_entry;

    // insert shifts right from the insertion point, pop shifts left
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            tbeq_pkg::CELL_INS: begin
                if (i_left_flag) begin
                    n_entry = i_left;
                end else if (o_flag) begin
                    n_entry = i_ctl.entry;
                end
            end
            tbeq_pkg::CELL_POP: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

FILE: hdl/tbeq_row.sv
`default_nettype none

module tbeq_row #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire tbeq_pkg::t_row_ctl i_ctl,
    output tbeq_pkg::t_entry        o_head,
    output tbeq_pkg::t_entry        o_second
);

    tbeq_pkg::t_entry w_entry [DEPTH];
    logic             w_flag  [DEPTH];

    // sorted chain, cell 0 holds the earliest event
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        tbeq_pkg::t_entry left_e;
        tbeq_pkg::t_entry right_e;
        logic             left_f;

        if (g == 0) begin : g_first
            assign left_e = '0;
            assign left_f = 1'b0;
        end else begin : g_mid
            assign left_e = w_entry[g-1];
            assign left_f = w_flag[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_e = w_entry[g];
        end else begin : g_inner
            assign right_e = w_entry[g+1];
        end

        tbeq_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_left     (left_e),
            .i_left_flag(left_f),
            .i_right    (right_e),
            .o_entry    (w_entry[g]),
            .o_flag     (w_flag[g])
        );
    end

    assign o_head   = w_entry[0];
    assign o_second = w_entry[1];

endmodule

`default_nettype wire
